[hdl/fcf_pkg.sv]
// Package for the full linear convolution FIR: item types, token type and constants.
// Used by fcf_cell, fcf_outbuf and full_linear_convolution_fir; depends on nothing.
package fcf_pkg;

    localparam int TAPS_DEF = 32;
    localparam int CNT_W = 7;
    localparam int ACC_W = 40;
    localparam int DATA_W = 16;
    localparam int IDX_W = 5;
    localparam int TC_W = 6;
    localparam logic [TC_W-1:0] TAP_COUNT_RST = 6'd32;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                      operation;
        logic [IDX_W-1:0]         tap_index;
        logic signed [DATA_W-1:0] data_value;
        logic                     last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] out_value;
        logic                    last_out;
    } out_item_t;

    typedef struct packed {
        logic                     valid;
        op_t                      operation;
        logic [IDX_W-1:0]         tap_index;
        logic signed [DATA_W-1:0] data;
        logic                     last_out;
        logic signed [ACC_W-1:0]  acc;
    } tok_t;

endpackage

[hdl/fcf_cell.sv]
// One tap cell of the FIR chain: holds a coefficient and one delay-line sample.
// Depends on fcf_pkg.
module fcf_cell import fcf_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv_i,
    input  logic [CNT_W-1:0]   taps_i,
    input  tok_t               tok_i,
    output tok_t               tok_o
);

    logic signed [DATA_W-1:0]   coef_reg;
    logic signed [DATA_W-1:0]   x_reg;
    logic                       valid_reg;
    tok_t                       tok_reg;
    tok_t                       tok_next;
    logic signed [2*DATA_W-1:0] prod;
    logic                       active;
    logic                       is_sample;

    assign active    = CNT_W'(IDX) < taps_i;
    assign is_sample = tok_i.valid && (tok_i.operation == OP_SAMPLE);
    assign prod      = coef_reg * tok_i.data;

    always_comb begin
        tok_next = tok_i;
        if (is_sample) begin
            tok_next.data = x_reg;
            if (active) begin
                tok_next.acc = tok_i.acc + ACC_W'(prod);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            x_reg     <= '0;
        end else if (adv_i) begin
            valid_reg <= tok_next.valid;
            if (is_sample) begin
                x_reg <= tok_i.last_out ? '0 : tok_i.data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_i) begin
            tok_reg <= tok_next;
            if (tok_i.valid && (tok_i.operation == OP_LOAD)
                && (CNT_W'(tok_i.tap_index) == CNT_W'(IDX))) begin
                coef_reg <= tok_i.data;
            end
        end
    end

    always_comb begin
        tok_o       = tok_reg;
        tok_o.valid = valid_reg;
    end

endmodule

[hdl/fcf_outbuf.sv]
// Two-entry output buffer between the tap chain and the result channel.
// Depends on fcf_pkg.
module fcf_outbuf import fcf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_i,
    input  out_item_t item_i,
    output logic      full_o,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    out_item_t  head_reg;
    out_item_t  head_next;
    out_item_t  tail_reg;
    out_item_t  tail_next;
    logic       pop;

    assign pop = (cnt_reg != 2'd0) && m_ready;

    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        unique case ({push_i, pop})
            2'b10: begin
                if (cnt_reg == 2'd0) begin
                    head_next = item_i;
                end else begin
                    tail_next = item_i;
                end
                cnt_next = cnt_reg + 2'd1;
            end
            2'b01: begin
                head_next = tail_reg;
                cnt_next  = cnt_reg - 2'd1;
            end
            2'b11: begin
                if (cnt_reg == 2'd1) begin
                    head_next = item_i;
                end else begin
                    head_next = tail_reg;
                    tail_next = item_i;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign full_o  = (cnt_reg == 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_item  = head_reg;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_i |-> (cnt_reg != 2'd2))
        else $error("result pushed into a full output buffer");
`endif

endmodule

[hdl/full_linear_convolution_fir.sv]
// Top level of the full linear convolution FIR: input stage, tail flush, tap chain.
// Depends on fcf_pkg, fcf_cell and fcf_outbuf.
//
// An input item either loads one Q1.15 coefficient (no result) or feeds one
// Q1.15 sample, which gives one 40-bit Q10.30 sum of products. The sample
// marked last is followed by one fewer tail outputs than the effective tap count
// (tap_count limited to 1..TAPS), computed as if zero samples followed; the final
// output carries last_out, and the delay line is then cleared. Items travel down
// a chain of TAPS cells, one cell per cycle while the chain is not held, so loads
// and samples take effect in the order they were accepted. One item is accepted
// per cycle unless the chain is held or a tail flush runs; each result passes
// through the registers of all TAPS cells and the output buffer before m_valid.
// During a tail flush s_ready stays low; it is also low whenever the chain is held.
// A two-entry output buffer holds finished results; when it is full the whole
// chain and input hold, and resume in the cycle after the receiver takes a result.
// Reset clears the delay line, the in-flight items, the output buffer and
// sets tap_count to 32; coefficients must be loaded before use. The user writes
// tap_count via cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module full_linear_convolution_fir import fcf_pkg::*; #(
    parameter int TAPS = TAPS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_we,
    input  logic [TC_W-1:0] cfg_wdata,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_item
);

    localparam int FW = $clog2(TAPS);

    logic [TC_W-1:0]  tap_count_reg;
    logic [FW-1:0]    flush_reg;
    logic [FW-1:0]    flush_next;
    logic [CNT_W-1:0] taps_eff;
    logic             adv;
    logic             full;
    logic             flushing;
    logic             accept;
    logic             push;
    tok_t             inj;
    tok_t             chain [TAPS+1];
    out_item_t        res;

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_eff = CNT_W'(1);
        end else if (CNT_W'(tap_count_reg) > CNT_W'(TAPS)) begin
            taps_eff = CNT_W'(TAPS);
        end else begin
            taps_eff = CNT_W'(tap_count_reg);
        end
    end

    assign adv      = !full;
    assign flushing = (flush_reg != '0);
    assign s_ready  = adv && !flushing;
    assign accept   = s_valid && s_ready;

    always_comb begin
        inj        = '0;
        flush_next = flush_reg;
        if (flushing) begin
            inj.valid     = adv;
            inj.operation = OP_SAMPLE;
            inj.last_out  = (flush_reg == FW'(1));
            if (adv) begin
                flush_next = flush_reg - FW'(1);
            end
        end else if (accept) begin
            inj.valid     = 1'b1;
            inj.operation = s_item.operation;
            inj.tap_index = s_item.tap_index;
            inj.data      = s_item.data_value;
            if (s_item.operation == OP_SAMPLE && s_item.last_sample) begin
                inj.last_out = (taps_eff == CNT_W'(1));
                flush_next   = FW'(taps_eff - CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_RST;
            flush_reg     <= '0;
        end else begin
            if (cfg_we) begin
                tap_count_reg <= cfg_wdata;
            end
            flush_reg <= flush_next;
        end
    end

    assign chain[0] = inj;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        fcf_cell #(
            .IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv_i   (adv),
            .taps_i  (taps_eff),
            .tok_i   (chain[g]),
            .tok_o   (chain[g+1])
        );
    end

    assign push = adv && chain[TAPS].valid && (chain[TAPS].operation == OP_SAMPLE);
    assign res  = '{out_value: chain[TAPS].acc, last_out: chain[TAPS].last_out};

    fcf_outbuf u_outbuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_i  (push),
        .item_i  (res),
        .full_o  (full),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef ASSERT_OFF
    a_flush_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        flushing |-> !s_ready)
        else $error("input accepted during a tail flush");

    a_flush_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_item.operation == OP_SAMPLE && s_item.last_sample)
        |=> (flush_reg == $past(FW'(taps_eff - CNT_W'(1)))))
        else $error("tail flush length does not follow the tap count");

    a_flush_counts_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (flushing && adv) |=> (flush_reg == $past(flush_reg) - FW'(1)))
        else $error("tail flush counter did not advance");
`endif

endmodule

[tb/full_linear_convolution_fir_test.sv]
// Self-checking testbench for full_linear_convolution_fir: directed and random
// blocks of samples and coefficient loads under random idling on both channels.
// Depends on fcf_pkg and the full_linear_convolution_fir RTL only.
module full_linear_convolution_fir_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fcf_pkg::*;

    localparam int TAPS = TAPS_DEF;
    localparam int SETTLE_CYCLES = 2 * TAPS + 8;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 165;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_we = 1'b0;
    logic [TC_W-1:0] cfg_wdata = '0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_item_t        s_item = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_item_t       m_item;

    logic signed [DATA_W-1:0] coef_mem [TAPS] = '{default: '0};
    logic signed [DATA_W-1:0] window [TAPS] = '{default: '0};
    logic [TC_W-1:0]          tap_count_q = TAP_COUNT_RST;
    out_item_t                pending [$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int fail_count = 0;
    int stall_cycles = 0;

    full_linear_convolution_fir #(
        .TAPS(TAPS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned active_taps();
        int unsigned m;
        m = 32'(tap_count_q);
        if (m < 1) m = 1;
        if (m > TAPS) m = TAPS;
        return m;
    endfunction

    function automatic void shift_window(logic signed [DATA_W-1:0] x);
        for (int i = TAPS - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = x;
    endfunction

    function automatic logic signed [ACC_W-1:0] window_sum(int unsigned m);
        longint acc;
        acc = 0;
        for (int j = 0; j < m; j++) acc += longint'(coef_mem[j]) * longint'(window[j]);
        return acc[ACC_W-1:0];
    endfunction

    function automatic void convolve_item(in_item_t it);
        int unsigned m;
        out_item_t r;
        if (it.operation == OP_LOAD) begin
            if (it.tap_index < TAPS) coef_mem[it.tap_index] = it.data_value;
            return;
        end
        m = active_taps();
        shift_window(it.data_value);
        r.out_value = window_sum(m);
        r.last_out = it.last_sample && (m == 1);
        pending.push_back(r);
        if (it.last_sample) begin
            for (int unsigned k = 1; k < m; k++) begin
                shift_window('0);
                r.out_value = window_sum(m);
                r.last_out = (k == m - 1);
                pending.push_back(r);
            end
            window = '{default: '0};
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return '0;
            3: return -16'sd1;
            default: return DATA_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic in_item_t make_load(int idx, logic signed [DATA_W-1:0] val);
        in_item_t it;
        it.operation = OP_LOAD;
        it.tap_index = IDX_W'(idx);
        it.data_value = val;
        it.last_sample = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_item_t make_sample(logic signed [DATA_W-1:0] val, bit last);
        in_item_t it;
        it.operation = OP_SAMPLE;
        it.tap_index = IDX_W'($urandom_range(31));
        it.data_value = val;
        it.last_sample = last;
        return it;
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    task automatic send_item(in_item_t it);
        while (tx_idle_on && $urandom_range(99) < 36) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        convolve_item(it);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_tap_count(logic [TC_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        tap_count_q = value;
    endtask

    task automatic test_coefficient_load();
        logic signed [DATA_W-1:0] val;
        for (int i = 0; i < TAPS; i++) begin
            case (i)
                0: val = -16'sd32768;
                1: val = 16'sd32767;
                2: val = -16'sd1;
                3: val = '0;
                default: val = pick_value();
            endcase
            send_item(make_load(i, val));
        end
    endtask

    task automatic test_reset_count_block();
        send_item(make_sample(16'sd32767, 1'b0));
        send_item(make_sample(-16'sd32768, 1'b0));
        send_item(make_sample(16'sd1, 1'b0));
        send_item(make_sample(-16'sd1, 1'b0));
        send_item(make_sample(-16'sd32768, 1'b1));
        settle();
    endtask

    task automatic test_single_tap();
        set_tap_count(6'd1);
        send_item(make_sample(-16'sd32768, 1'b0));
        send_item(make_sample(16'sd32767, 1'b1));
        settle();
        set_tap_count(6'd0);
        send_item(make_sample(-16'sd32768, 1'b1));
        settle();
    endtask

    task automatic test_count_saturation();
        set_tap_count(6'd63);
        send_item(make_sample(16'sd32767, 1'b0));
        send_item(make_sample(-16'sd32768, 1'b1));
        settle();
    endtask

    task automatic test_count_change_in_block();
        set_tap_count(6'd5);
        send_item(make_sample(pick_value(), 1'b0));
        send_item(make_sample(pick_value(), 1'b0));
        send_item(make_sample(pick_value(), 1'b0));
        settle();
        set_tap_count(6'd9);
        send_item(make_sample(pick_value(), 1'b0));
        send_item(make_sample(pick_value(), 1'b1));
        settle();
    endtask

    task automatic test_reload_in_stream();
        set_tap_count(6'd4);
        send_item(make_sample(16'sd12345, 1'b0));
        send_item(make_load(1, 16'sd32767));
        send_item(make_sample(-16'sd2222, 1'b0));
        send_item(make_load(0, -16'sd32768));
        send_item(make_sample(16'sd32767, 1'b1));
        settle();
    endtask

    task automatic test_random_blocks();
        int sent;
        int phase;
        int len;
        logic [TC_W-1:0] count;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            case ($urandom_range(9))
                0: count = 6'd0;
                1: count = 6'd1;
                2: count = 6'd32;
                3: count = TC_W'($urandom_range(33, 63));
                default: count = TC_W'($urandom_range(2, 12));
            endcase
            set_tap_count(count);
            tx_idle_on = (phase != 2);
            rx_idle_on = (phase != 2);
            repeat ($urandom_range(1, 4)) begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    if ($urandom_range(9) == 0) begin
                        send_item(make_load($urandom_range(31), pick_value()));
                        sent++;
                    end
                    send_item(make_sample(pick_value(),
                                          (i == len - 1) && ($urandom_range(7) != 0)));
                    sent++;
                end
            end
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    always @(negedge aclk) begin
        m_ready <= !rx_idle_on || ($urandom_range(99) >= 36);
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending.size() == 0) begin
                log_failure($sformatf("unexpected result: value %0d last %0b",
                                      m_item.out_value, m_item.last_out));
            end else begin
                want = pending.pop_front();
                if (m_item.out_value !== want.out_value || m_item.last_out !== want.last_out) begin
                    log_failure($sformatf(
                        "result mismatch: expected value %0d last %0b, got value %0d last %0b",
                        want.out_value, want.last_out, m_item.out_value, m_item.last_out));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_coefficient_load();
        test_reset_count_block();
        test_single_tap();
        test_count_saturation();
        test_count_change_in_block();
        test_reload_in_stream();
        test_random_blocks();
        settle();
        if (fail_count == 0 && pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
